// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/mts_pkg.sv -----
`default_nettype none

package mts_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

    typedef struct packed {
        logic exec;
        logic fetch_load;
        logic out_load;
    } mts_cmd_t;

    typedef struct packed {
        logic need_fetch;
    } mts_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/min_tracking_stack_top.sv -----
// Min-tracking stack: signed 32-bit entries with the current minimum kept
// in one register (entries below the minimum are stored as 2*value-min).
// Input channel: in_valid/in_ready with command (push/pop/peek) and value.
// Output channel: out_valid/out_ready with top_value, min_value, is_empty
// and status; exactly one result per accepted command, in order.
// Timing: push, peek and pop down to empty load the result register at
// the accept edge if the output register is free; a pop that leaves entries
// goes through S_FETCH for the registered read of the new top from the stack
// memory. Throughput: one command per cycle for push and peek while the
// output register is free; such pops hold in_ready low in S_FETCH.
// Stall: a waiting result is held in the output register; the next command
// is still accepted and executes, then the controller holds in_ready low
// until that result can move into the output register.
// Reset (rst_n, async low): stack empty, minimum zero, no result pending.
// No clearing pass; memory contents are undefined until pushed.
`default_nettype none

module min_tracking_stack_top #(
    parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      top_value,
    output logic signed [31:0]      min_value,
    output logic                    is_empty,
    output logic [1:0]              status
);

    mts_pkg::mts_cmd_t  ctl;
    mts_pkg::mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .command   (command),
        .value     (value),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mts_datapath.sv -----
`default_nettype none

`include "assert_macros.svh"

module mts_datapath #(
    parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mts_pkg::mts_cmd_t ctl,
    output mts_pkg::mts_stat_t     stat,
    input  wire logic [1:0]        command,
    input  wire logic signed [31:0] value,
    output logic signed [31:0]     top_value,
    output logic signed [31:0]     min_value,
    output logic                   is_empty,
    output logic [1:0]             status
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    logic signed [33:0] mem [STACK_DEPTH];
    logic signed [33:0] rd_data_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [33:0] top_reg, top_next;
    logic [1:0]         status_reg, status_next, status_calc;

    logic signed [31:0] top_value_reg;
    logic signed [31:0] min_value_reg;
    logic               is_empty_reg;
    logic [1:0]         status_out_reg;

    logic               wr_en, rd_en;
    logic               full, empty;
    logic signed [33:0] min_ext, push_entry, restore;
    logic signed [31:0] result_top;
    logic               push_below;

    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign min_ext = {{2{min_reg[31]}}, min_reg};

    assign push_below = !empty && (value < min_reg);
    assign push_entry = push_below
        ? ($signed({value[31], value, 1'b0}) - min_ext)
        : $signed({{2{value[31]}}, value});
    assign restore = $signed({min_reg[31], min_reg, 1'b0}) - top_reg;

    assign stat.need_fetch = (command == mts_pkg::CMD_POP) && (count_reg > CW'(1));

    always_comb
    begin
        count_next  = count_reg;
        min_next    = min_reg;
        top_next    = top_reg;
        status_calc = mts_pkg::ST_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (ctl.exec)
        begin
            case (command)
                mts_pkg::CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_calc = mts_pkg::ST_PUSH_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        top_next   = push_entry;
                        count_next = count_reg + CW'(1);
                        if (empty || push_below)
                        begin
                            min_next = value;
                        end
                    end
                end
                mts_pkg::CMD_POP:
                begin
                    if (empty)
                    begin
                        status_calc = mts_pkg::ST_POP_EMPTY;
                    end
                    else
                    begin
                        if (top_reg < min_ext)
                        begin
                            min_next = restore[31:0];
                        end
                        count_next = count_reg - CW'(1);
                        rd_en      = stat.need_fetch;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ctl.fetch_load)
        begin
            top_next = rd_data_reg;
        end
    end

    assign status_next = ctl.exec ? status_calc : status_reg;

    always_comb
    begin
        if (count_next == '0)
        begin
            result_top = '1;
        end
        else if (top_next >= $signed({{2{min_next[31]}}, min_next}))
        begin
            result_top = top_next[31:0];
        end
        else
        begin
            result_top = min_next;
        end
    end

    // stack memory: push writes at count, pop reads the new top at count-2
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= push_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[AW'(count_reg - CW'(2))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            min_reg    <= '0;
            status_reg <= mts_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            min_reg    <= min_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (ctl.out_load)
        begin
            top_value_reg  <= result_top;
            min_value_reg  <= min_next;
            is_empty_reg   <= (count_next == '0);
            status_out_reg <= status_next;
        end
    end

    assign top_value = top_value_reg;
    assign min_value = min_value_reg;
    assign is_empty  = is_empty_reg;
    assign status    = status_out_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(STACK_DEPTH))
    `ASSERT_NEXT(a_full_push_holds, clk, rst_n,
        ctl.exec && (command == mts_pkg::CMD_PUSH) && full,
        (count_reg == $past(count_reg)) && (min_reg == $past(min_reg)))
    `ASSERT_ALWAYS(a_fetch_after_read, clk, rst_n, !ctl.fetch_load || $past(rd_en))

endmodule

`default_nettype wire

// ----- rtl/core/mts_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

module mts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t       ctl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ctl.exec       = 1'b0;
        ctl.fetch_load = 1'b0;
        ctl.out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.exec = 1'b1;
                    if (stat.need_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                    else if (out_free)
                    begin
                        ctl.out_load = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_FETCH:
            begin
                ctl.fetch_load = 1'b1;
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_fetch_from_idle, clk, rst_n, state_reg == S_FETCH,
        $past(state_reg) == S_IDLE ? 1'b0 : 1'b0 || state_reg != S_FETCH)
    `ASSERT_ALWAYS(a_fetch_entry, clk, rst_n,
        state_reg != S_FETCH || $past(state_reg) == S_IDLE)
    `ASSERT_NEXT(a_emit_means_busy, clk, rst_n, state_reg == S_EMIT && !out_free,
        state_reg == S_EMIT && out_valid_reg)

endmodule

`default_nettype wire

// ----- tb/sv/min_stack_checker.sv -----
`timescale 1ns / 100ps

module min_stack_checker #(
    parameter int DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] top_value,
    input  logic signed [31:0] min_value,
    input  logic               is_empty,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] top;
        logic signed [31:0] minv;
        logic               empty;
        logic [1:0]         st;
    } stack_view_t;

    // model state: raw values or 34-bit markers
    logic signed [33:0] entries [DEPTH];
    int                 used_entries = 0;
    logic signed [31:0] tracked_min = '0;
    stack_view_t        expected_views [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic apply_command(input logic [1:0] cmd, input logic signed [31:0] val,
                                 output stack_view_t view);
        logic signed [33:0] wide_val;
        logic signed [33:0] wide_min;
        logic signed [33:0] entry;
        logic signed [33:0] restored;
        wide_val = val;
        wide_min = tracked_min;
        view.st = mts_pkg::ST_OK;
        if (cmd == mts_pkg::CMD_PUSH)
        begin
            if (used_entries >= DEPTH)
                view.st = mts_pkg::ST_PUSH_FULL;
            else if (used_entries == 0)
            begin
                entries[0] = wide_val;
                used_entries = 1;
                tracked_min = val;
            end
            else if (val >= tracked_min)
            begin
                entries[used_entries] = wide_val;
                used_entries++;
            end
            else
            begin
                entries[used_entries] = 2 * wide_val - wide_min;
                used_entries++;
                tracked_min = val;
            end
        end
        else if (cmd == mts_pkg::CMD_POP)
        begin
            if (used_entries == 0)
                view.st = mts_pkg::ST_POP_EMPTY;
            else
            begin
                entry = entries[used_entries - 1];
                if (entry < wide_min)
                begin
                    restored = 2 * wide_min - entry;
                    tracked_min = restored[31:0];
                end
                used_entries--;
            end
        end
        wide_min = tracked_min;
        if (used_entries == 0)
            view.top = -1;
        else
        begin
            entry = entries[used_entries - 1];
            view.top = (entry >= wide_min) ? entry[31:0] : tracked_min;
        end
        view.minv = tracked_min;
        view.empty = (used_entries == 0);
    endtask

    task automatic report(input string field, input logic signed [31:0] exp_val,
                          input logic signed [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        stack_view_t view;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual top %0d min %0d",
                             $time, top_value, min_value);
                    fail_count++;
                end
                else
                begin
                    view = expected_views.pop_front();
                    report("top_value", view.top, top_value);
                    report("min_value", view.minv, min_value);
                    report("is_empty", {31'd0, view.empty}, {31'd0, is_empty});
                    report("status", {30'd0, view.st}, {30'd0, status});
                end
            end
            if (in_valid && in_ready)
            begin
                apply_command(command, value, view);
                expected_views.push_back(view);
            end
            pending = expected_views.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0]         CMD_UNDEF = 2'd3;
    localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam int                 CYCLE_LIMIT = 200000;
    localparam int                 HOLD_CYCLES = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;
    bit hold_req = 0;

    min_tracking_stack_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .status    (status)
    );

    min_stack_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .top_value  (top_value),
        .min_value  (min_value),
        .is_empty   (is_empty),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
        in_valid <= 1;
        command <= cmd;
        value <= val;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return $signed($urandom_range(20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(19);
        if (r < 10)
            return mts_pkg::CMD_PUSH;
        else if (r < 16)
            return mts_pkg::CMD_POP;
        else if (r < 19)
            return mts_pkg::CMD_PEEK;
        return CMD_UNDEF;
    endfunction

    task automatic descend_and_unwind();
        longint lv;
        int n;
        n = $urandom_range(4, 12);
        lv = pick_value();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_item(mts_pkg::CMD_PEEK, $urandom);
            send_item(mts_pkg::CMD_PUSH, 32'(lv));
            lv = lv - $urandom_range(1, 1 << 24);
            if (lv < -64'sd2147483648)
                lv = -64'sd2147483648;
        end
        for (int i = 0; i < n; i++)
        begin
            send_item(mts_pkg::CMD_POP, $urandom);
            if ($urandom_range(3) == 0)
                send_item(mts_pkg::CMD_PEEK, $urandom);
        end
    endtask

    task automatic run_phase(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                    repeat (20) send_item(pick_command(), pick_value());
                3:
                begin
                    repeat (66) send_item(mts_pkg::CMD_PUSH, pick_value());
                    send_item(mts_pkg::CMD_PEEK, $urandom);
                end
                4:
                begin
                    repeat (66) send_item(mts_pkg::CMD_POP, $urandom);
                    send_item(CMD_UNDEF, $urandom);
                end
                5, 6:
                    descend_and_unwind();
                7:
                    repeat (10) send_item(2'($urandom_range(3)), $urandom);
                default:
                begin
                    repeat (15) send_item(mts_pkg::CMD_PUSH, pick_value());
                    repeat (15) send_item($urandom_range(3) == 0 ? mts_pkg::CMD_PEEK
                                                                 : mts_pkg::CMD_POP,
                                          $urandom);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        command = mts_pkg::CMD_PEEK;
        value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty stack, underflow, undefined code
        send_item(mts_pkg::CMD_PEEK, 32'sd5);
        send_item(mts_pkg::CMD_POP, 32'sd7);
        send_item(CMD_UNDEF, VAL_MIN);
        // widest marker: push min below max
        send_item(mts_pkg::CMD_PUSH, VAL_MAX);
        send_item(mts_pkg::CMD_PUSH, VAL_MIN);
        send_item(mts_pkg::CMD_PEEK, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_PUSH, VAL_MIN);
        send_item(mts_pkg::CMD_PUSH, VAL_MAX);
        send_item(mts_pkg::CMD_PUSH, VAL_MIN);
        send_item(mts_pkg::CMD_PUSH, -32'sd1);
        send_item(CMD_UNDEF, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_PUSH, 32'sd0);
        send_item(mts_pkg::CMD_PUSH, -32'sd1);
        send_item(mts_pkg::CMD_PUSH, 32'sd1);
        send_item(mts_pkg::CMD_PUSH, -32'sd1);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);
        send_item(mts_pkg::CMD_POP, 32'sd0);

        idle_pct = 0;
        stall_pct = 0;
        run_phase(320);
        idle_pct = 48;
        stall_pct = 0;
        run_phase(320);
        idle_pct = 0;
        stall_pct = 48;
        run_phase(320);
        idle_pct = 18;
        stall_pct = 18;
        run_phase(320);

        // long receiver hold-off while items keep coming
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1;
        run_phase(70);

        in_valid <= 0;
        while (pending != 0 || hold_req) @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mts_pkg.sv
rtl/core/mts_datapath.sv
rtl/core/mts_ctrl.sv
rtl/core/min_tracking_stack_top.sv
tb/sv/min_stack_checker.sv
tb/sv/testbench.sv
